/* src/bstl_pkg.sv */
// shared constants, types and float compare helpers for the binary stl deframer
// no dependencies
package bstl_pkg;

  localparam int unsigned HdrBytes      = 80;
  localparam int unsigned DataStart     = 84;
  localparam int unsigned LastRecByte   = 49;
  localparam int unsigned LastVecByte   = 11;
  localparam int unsigned VecPerRec     = 4;
  localparam logic [31:0] FloatZero     = 32'h0000_0000;
  localparam logic [31:0] FloatMinInit  = 32'h47C3_4FFF;

  typedef struct packed {
    logic [31:0] max_bits;
    logic [31:0] min_bits;
    logic        neg;
  } stats_t;

  function automatic logic f_is_nan(input logic [31:0] a);
    f_is_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  // ieee single a < b, false on nan, +0 == -0
  function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
    logic r;
    r = 1'b0;
    if (f_is_nan(a) || f_is_nan(b)) begin
      r = 1'b0;
    end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
      r = 1'b0;
    end else if (a[31] != b[31]) begin
      r = a[31];
    end else if (!a[31]) begin
      r = a[30:0] < b[30:0];
    end else begin
      r = a[30:0] > b[30:0];
    end
    f_lt = r;
  endfunction

endpackage

/* src/bstl_fstat.sv */
// running max, min and negative flag folded over the three coordinates of a vector
// depends on bstl_pkg
module bstl_fstat (
  input  bstl_pkg::stats_t cur,
  input  logic [31:0]      x_bits,
  input  logic [31:0]      y_bits,
  input  logic [31:0]      z_bits,
  output bstl_pkg::stats_t nxt
);

  bstl_pkg::stats_t s1;
  bstl_pkg::stats_t s2;

  function automatic bstl_pkg::stats_t fold(input bstl_pkg::stats_t s, input logic [31:0] v);
    bstl_pkg::stats_t r;
    r = s;
    if (bstl_pkg::f_lt(v, bstl_pkg::FloatZero)) r.neg = 1'b1;
    if (bstl_pkg::f_lt(s.max_bits, v)) r.max_bits = v;
    if (bstl_pkg::f_lt(v, s.min_bits)) r.min_bits = v;
    fold = r;
  endfunction

  always_comb begin
    s1  = fold(cur, x_bits);
    s2  = fold(s1, y_bits);
    nxt = fold(s2, z_bits);
  end

endmodule

/* src/binary_stl_triangle_deframer.sv */
// binary stl deframer top level: header skip, count capture, vector assembly, stats
// depends on bstl_pkg and bstl_fstat
//
// usage
// - input channel: one file byte per transaction on in_data_byte; in_file_start
//   marks byte 0 of a new file and restarts the parse and the statistics
// - bytes 0..79 are skipped, bytes 80..83 form the little-endian triangle count
// - then 50-byte records: four 12-byte vectors (normal, v0, v1, v2) and two
//   attribute bytes that are dropped
// - output channel: one transaction per completed vector with x, y, z bits,
//   triangle index, declared count and running max, min and negative flag
// - latency: result valid the cycle after the last byte of a vector is taken
// - throughput: one byte per cycle unless a held result is stalled; all
//   per-byte work sits between the accepted byte and the result register
// - while a held result is stalled the input is stalled too; once the result
//   is taken a new byte is accepted in the same cycle
// - reset (rst_n low, synchronous) clears all parse state and the output
//   valid; the first byte after reset counts as byte 0
module binary_stl_triangle_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_file_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_vector_kind,
  output logic [31:0] out_x_bits,
  output logic [31:0] out_y_bits,
  output logic [31:0] out_z_bits,
  output logic [31:0] out_triangle_number,
  output logic [31:0] out_declared_count,
  output logic [31:0] out_max_so_far,
  output logic [31:0] out_min_so_far,
  output logic        out_saw_negative
);

  logic [6:0]        hdr_r, hdr_nxt, hdr_c;
  logic [31:0]       cnt_r, cnt_nxt, cnt_c;
  logic [5:0]        rec_r, rec_nxt, rec_c;
  logic [2:0]        slot_r, slot_nxt, slot_c;
  logic [31:0]       w_r [3];
  logic [31:0]       w_nxt [3];
  logic [31:0]       w_c [3];
  logic [31:0]       tri_r, tri_nxt, tri_c;
  bstl_pkg::stats_t  st_r, st_nxt, st_c, st_fold;
  logic              ov_r;
  logic [1:0]        kind_r;
  logic [31:0]       ox_r, oy_r, oz_r, otri_r, ocnt_r;
  bstl_pkg::stats_t  ost_r;
  logic              accept, emit;
  logic [3:0]        lane;
  logic [31:0]       wa [3];
  bstl_pkg::stats_t  st_init;

  assign st_init = '{max_bits: bstl_pkg::FloatZero, min_bits: bstl_pkg::FloatMinInit,
                     neg: 1'b0};

  assign in_stall = ov_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    hdr_c  = in_file_start ? 7'd0  : hdr_r;
    cnt_c  = in_file_start ? 32'd0 : cnt_r;
    rec_c  = in_file_start ? 6'd0  : rec_r;
    slot_c = in_file_start ? 3'd0  : slot_r;
    tri_c  = in_file_start ? 32'd0 : tri_r;
    st_c   = in_file_start ? st_init : st_r;
    for (int i = 0; i < 3; i++) w_c[i] = in_file_start ? 32'd0 : w_r[i];
  end

  always_comb begin
    if (rec_c < 6'd12)      lane = rec_c[3:0];
    else if (rec_c < 6'd24) lane = 4'(rec_c - 6'd12);
    else if (rec_c < 6'd36) lane = 4'(rec_c - 6'd24);
    else                    lane = 4'(rec_c - 6'd36);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wa[i] = w_c[i];
      if (lane[3:2] == 2'(i)) begin
        case (lane[1:0])
          2'd0:    wa[i][7:0]   = in_data_byte;
          2'd1:    wa[i][15:8]  = in_data_byte;
          2'd2:    wa[i][23:16] = in_data_byte;
          default: wa[i][31:24] = in_data_byte;
        endcase
      end
    end
  end

  bstl_fstat u_fstat (
    .cur    (st_c),
    .x_bits (wa[0]),
    .y_bits (wa[1]),
    .z_bits (wa[2]),
    .nxt    (st_fold)
  );

  always_comb begin
    hdr_nxt  = hdr_c;
    cnt_nxt  = cnt_c;
    rec_nxt  = rec_c;
    slot_nxt = slot_c;
    tri_nxt  = tri_c;
    st_nxt   = st_c;
    emit     = 1'b0;
    for (int i = 0; i < 3; i++) w_nxt[i] = w_c[i];
    if (hdr_c < 7'(bstl_pkg::DataStart)) begin
      hdr_nxt = hdr_c + 7'd1;
      if (hdr_c >= 7'(bstl_pkg::HdrBytes)) begin
        case (hdr_c[1:0])
          2'd0:    cnt_nxt[7:0]   = cnt_c[7:0]   | in_data_byte;
          2'd1:    cnt_nxt[15:8]  = cnt_c[15:8]  | in_data_byte;
          2'd2:    cnt_nxt[23:16] = cnt_c[23:16] | in_data_byte;
          default: cnt_nxt[31:24] = cnt_c[31:24] | in_data_byte;
        endcase
      end
    end else begin
      if (rec_c >= 6'(bstl_pkg::LastRecByte)) begin
        rec_nxt  = 6'd0;
        tri_nxt  = tri_c + 32'd1;
        slot_nxt = 3'd0;
      end else begin
        rec_nxt = rec_c + 6'd1;
        if (slot_c < 3'(bstl_pkg::VecPerRec)) begin
          for (int i = 0; i < 3; i++) w_nxt[i] = wa[i];
          if (lane == 4'(bstl_pkg::LastVecByte)) begin
            emit     = 1'b1;
            st_nxt   = st_fold;
            slot_nxt = slot_c + 3'd1;
            for (int i = 0; i < 3; i++) w_nxt[i] = 32'd0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r  <= 7'd0;
      cnt_r  <= 32'd0;
      rec_r  <= 6'd0;
      slot_r <= 3'd0;
      tri_r  <= 32'd0;
      st_r   <= st_init;
      ov_r   <= 1'b0;
      for (int i = 0; i < 3; i++) w_r[i] <= 32'd0;
    end else begin
      if (accept) begin
        hdr_r  <= hdr_nxt;
        cnt_r  <= cnt_nxt;
        rec_r  <= rec_nxt;
        slot_r <= slot_nxt;
        tri_r  <= tri_nxt;
        st_r   <= st_nxt;
        for (int i = 0; i < 3; i++) w_r[i] <= w_nxt[i];
      end
      if (accept) begin
        ov_r <= emit;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      kind_r <= slot_c[1:0];
      ox_r   <= wa[0];
      oy_r   <= wa[1];
      oz_r   <= wa[2];
      otri_r <= tri_c;
      ocnt_r <= cnt_c;
      ost_r  <= st_fold;
    end
  end

  assign out_valid           = ov_r;
  assign out_vector_kind     = kind_r;
  assign out_x_bits          = ox_r;
  assign out_y_bits          = oy_r;
  assign out_z_bits          = oz_r;
  assign out_triangle_number = otri_r;
  assign out_declared_count  = ocnt_r;
  assign out_max_so_far      = ost_r.max_bits;
  assign out_min_so_far      = ost_r.min_bits;
  assign out_saw_negative    = ost_r.neg;

`ifndef SYNTHESIS
  a_out_after_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> hdr_r == 7'(bstl_pkg::DataStart))
    else $error("result before header done");
  a_rec_range: assert property (@(posedge clk) disable iff (!rst_n)
    rec_r <= 6'(bstl_pkg::LastRecByte))
    else $error("record offset out of range");
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= 3'(bstl_pkg::VecPerRec))
    else $error("vector slot out of range");
  a_last_vec: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && emit && slot_c == 3'd3) |=> slot_r == 3'(bstl_pkg::VecPerRec))
    else $error("slot not advanced after last vector");
`endif

endmodule

/* tb/bstl_deframer_checker.sv */
// checker for the binary stl deframer: watches both channels, predicts vectors and compares
// depends on bstl_pkg for the framing constants and the float reset constants
module bstl_deframer_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_file_start,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_vector_kind,
  input  logic [31:0] out_x_bits,
  input  logic [31:0] out_y_bits,
  input  logic [31:0] out_z_bits,
  input  logic [31:0] out_triangle_number,
  input  logic [31:0] out_declared_count,
  input  logic [31:0] out_max_so_far,
  input  logic [31:0] out_min_so_far,
  input  logic        out_saw_negative,
  output int          fail_count,
  output int          pending_vectors
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] x, y, z, tri_idx, count, vmax, vmin;
    logic        neg;
  } vec_t;

  vec_t vec_q[$];

  logic [6:0]  hdr_pos;
  logic [31:0] tri_count_reg;
  logic [5:0]  rec_off;
  logic [2:0]  slot;
  logic [31:0] words[3];
  logic [31:0] tri_cnt, vmax, vmin;
  logic        neg;

  function automatic bit isnan(logic [31:0] a);
    return a[30:23] == 8'hff && a[22:0] != 0;
  endfunction

  // ieee less-than, false on nan, signed zeros equal
  function automatic bit flt(logic [31:0] a, logic [31:0] b);
    if (isnan(a) || isnan(b)) return 0;
    if (a[30:0] == 0 && b[30:0] == 0) return 0;
    if (a[31] != b[31]) return a[31];
    if (!a[31]) return a[30:0] < b[30:0];
    return a[30:0] > b[30:0];
  endfunction

  task automatic clear_parse();
    hdr_pos = 0; tri_count_reg = 0; rec_off = 0; slot = 0;
    words[0] = 0; words[1] = 0; words[2] = 0;
    tri_cnt = 0; vmax = bstl_pkg::FloatZero; vmin = bstl_pkg::FloatMinInit; neg = 0;
  endtask

  task automatic predict_byte(logic [7:0] b, logic fs);
    int p;
    int lane;
    vec_t v;
    if (fs) clear_parse();
    if (hdr_pos < bstl_pkg::DataStart) begin
      p = hdr_pos;
      hdr_pos++;
      if (p >= bstl_pkg::HdrBytes) tri_count_reg[8*(p-bstl_pkg::HdrBytes) +: 8] = b;
      return;
    end
    p = rec_off;
    rec_off = (p >= bstl_pkg::LastRecByte) ? 0 : p + 1;
    if (p >= bstl_pkg::LastRecByte) begin
      tri_cnt++;
      slot = 0;
      return;
    end
    if (slot >= bstl_pkg::VecPerRec) return;
    lane = p % 12;
    words[lane/4][8*(lane%4) +: 8] = b;
    if (lane != bstl_pkg::LastVecByte) return;
    for (int k = 0; k < 3; k++) begin
      if (flt(words[k], bstl_pkg::FloatZero)) neg = 1;
      if (flt(vmax, words[k])) vmax = words[k];
      if (flt(words[k], vmin)) vmin = words[k];
    end
    v = '{slot[1:0], words[0], words[1], words[2], tri_cnt, tri_count_reg, vmax, vmin, neg};
    vec_q.push_back(v);
    words[0] = 0; words[1] = 0; words[2] = 0;
    slot++;
  endtask

  task automatic compare_vector();
    vec_t e;
    vec_t a;
    a = '{out_vector_kind, out_x_bits, out_y_bits, out_z_bits, out_triangle_number,
          out_declared_count, out_max_so_far, out_min_so_far, out_saw_negative};
    if (vec_q.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected vector transaction %h", $time, a);
      return;
    end
    e = vec_q.pop_front();
    if (e.kind != a.kind) begin
      fail_count++; $display("%0t: kind exp %0d got %0d", $time, e.kind, a.kind);
    end
    if (e.x != a.x) begin
      fail_count++; $display("%0t: x exp %h got %h", $time, e.x, a.x);
    end
    if (e.y != a.y) begin
      fail_count++; $display("%0t: y exp %h got %h", $time, e.y, a.y);
    end
    if (e.z != a.z) begin
      fail_count++; $display("%0t: z exp %h got %h", $time, e.z, a.z);
    end
    if (e.tri_idx != a.tri_idx) begin
      fail_count++; $display("%0t: triangle exp %0d got %0d", $time, e.tri_idx, a.tri_idx);
    end
    if (e.count != a.count) begin
      fail_count++; $display("%0t: count exp %h got %h", $time, e.count, a.count);
    end
    if (e.vmax != a.vmax) begin
      fail_count++; $display("%0t: max exp %h got %h", $time, e.vmax, a.vmax);
    end
    if (e.vmin != a.vmin) begin
      fail_count++; $display("%0t: min exp %h got %h", $time, e.vmin, a.vmin);
    end
    if (e.neg != a.neg) begin
      fail_count++; $display("%0t: negative exp %0d got %0d", $time, e.neg, a.neg);
    end
  endtask

  initial begin
    fail_count = 0;
    clear_parse();
  end

  assign pending_vectors = vec_q.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parse();
    end else begin
      if (out_valid && !out_stall) compare_vector();
      if (in_valid && !in_stall) predict_byte(in_data_byte, in_file_start);
    end
  end
endmodule

/* tb/tb_binary_stl_triangle_deframer.sv */
// stimulus and verdict for the binary stl deframer: files of random triangles with noise
// depends on bstl_pkg, the deframer and bstl_deframer_checker
module tb_binary_stl_triangle_deframer;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 0;
  logic        in_file_start = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  out_vector_kind;
  logic [31:0] out_x_bits, out_y_bits, out_z_bits, out_triangle_number;
  logic [31:0] out_declared_count, out_max_so_far, out_min_so_far;
  logic        out_saw_negative;
  int          fail_count, pending_vectors;
  int          cycle_cnt = 0;
  bit          calm = 0;
  bit          hold_rx = 0;
  bit          hold_done = 0;

  always #1 clk = ~clk;

  binary_stl_triangle_deframer DUT (.*);
  bstl_deframer_checker u_checker (.*);

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 400000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver stall, with one long hold-off
  initial begin
    int n;
    n = 0;
    while (!hold_rx) @(posedge clk);
    out_stall <= 1;
    while (n < 300) begin
      @(posedge clk);
      n++;
    end
    hold_done = 1;
    forever begin
      @(posedge clk);
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 32);
    end
  end

  task automatic send_byte(logic [7:0] b, logic fs);
    while (!calm && $urandom_range(99) < 32) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data_byte <= b;
    in_file_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_float();
    case ($urandom_range(9))
      0: return 32'h7fc0_0000 | $urandom_range(255);
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return {1'($urandom_range(1)), 8'hff, 23'd0};
      4: return $urandom;
      5: return {1'b1, 8'd120 + 8'($urandom_range(20)), 23'($urandom)};
      default: return {1'b0, 8'd110 + 8'($urandom_range(40)), 23'($urandom)};
    endcase
  endfunction

  task automatic send_file(int ntri, logic [31:0] count, bit with_start);
    logic [31:0] w;
    for (int i = 0; i < 80; i++) send_byte(8'($urandom), with_start && i == 0);
    for (int i = 0; i < 4; i++) send_byte(count[8*i +: 8], 0);
    for (int t = 0; t < ntri; t++) begin
      for (int k = 0; k < 12; k++) begin
        w = rand_float();
        for (int i = 0; i < 4; i++) send_byte(w[8*i +: 8], 0);
      end
      send_byte(8'($urandom), 0);
      send_byte(8'($urandom), 0);
    end
  endtask

  initial begin
    logic [31:0] w;
    int sent;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    // no file start after reset: header then directed extreme vectors
    for (int i = 0; i < 84; i++) send_byte(i == 80 ? 8'hff : 8'h00, 0);
    for (int k = 0; k < 12; k++) begin
      case (k)
        0: w = 32'hffff_ffff;
        1: w = 32'h7f80_0000;
        2: w = 32'hff80_0000;
        3: w = 32'h8000_0000;
        4: w = 32'h7f7f_ffff;
        5: w = 32'hff7f_ffff;
        default: w = 32'h0000_0001 << k;
      endcase
      for (int i = 0; i < 4; i++) send_byte(w[8*i +: 8], 0);
    end
    send_byte(8'hff, 0);
    send_byte(8'hff, 0);
    send_file(2, 32'hffff_ffff, 1);
    send_file(1, 32'h0, 1);
    // back-pressure: sender keeps offering while the receiver holds
    hold_rx = 1;
    send_file(3, $urandom, 1);
    while (!hold_done) @(posedge clk);
    in_valid <= 0;
    while (pending_vectors != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    sent = 0;
    while (sent < 1000) begin
      int nt;
      calm = (sent > 300 && sent < 600);
      nt = $urandom_range(3);
      if ($urandom_range(9) == 0) begin
        // noise: restart mid-stream
        for (int i = 0; i < 30; i++) send_byte(8'($urandom), i == 0);
        sent += 30;
      end else begin
        send_file(nt, $urandom, $urandom_range(7) != 0);
        sent += 84 + 50 * nt;
      end
    end
    calm = 0;
    in_valid <= 0;
    while (pending_vectors != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_vectors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
